// ===== hw/rtl/asu_pkg.sv =====
package asu_pkg;

   // default width of the input integer
   localparam int unsigned NUM_WIDTH_DEF = 16;

   // result width and its saturation value
   localparam int unsigned SUM_WIDTH = 18;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

   // first trial divisor
   localparam int unsigned FIRST_DIVISOR = 2;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_EVAL  = 7'b0000100,
      ST_MGEO  = 7'b0001000,
      ST_MPROD = 7'b0010000,
      ST_MLAST = 7'b0100000,
      ST_FINAL = 7'b1000000
   } state_type;

endpackage

// ===== hw/rtl/aliquot_sum_unit_core.sv =====
// Sum of proper divisors of an unsigned integer. Pulse start with req_number while busy is
// low; the beat is taken at that edge and busy stays high until the result is out. The
// result rsp_proper_sum shows for exactly one cycle with rsp_valid and the receiver cannot
// stall it, so it must take it in that cycle. The number is factored by trial division with
// one shared adder that serves as a restoring divider (one quotient bit a cycle) and as a
// shift-add multiplier (one multiplier bit a cycle). Each trial divisor takes a full division
// and a check. Each time a divisor goes in, the geometric sum is extended by a multiply by the
// divisor plus one, and the trial is repeated on the quotient; the end of a prime power run
// folds that sum into the running product with a multiply. Worst case at the default width
// is a large prime: 255 trial divisors, then the multiply by the leftover prime and the
// final subtract before the result.
// A result above 262143 (only possible with NUM_WIDTH over 16) saturates; input 0 gives 0.
module aliquot_sum_unit_core #(
   parameter int unsigned NUM_WIDTH = asu_pkg::NUM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [NUM_WIDTH-1:0]           req_number,
   output logic                           rsp_valid,
   output logic [asu_pkg::SUM_WIDTH-1:0]  rsp_proper_sum
);

   // datapath width: sigma(n) stays below 8 * n
   localparam int unsigned W     = NUM_WIDTH + 3;
   localparam int unsigned SUM_W = asu_pkg::SUM_WIDTH;
   localparam int unsigned SAT_W = (W > SUM_W) ? W : SUM_W;
   localparam int unsigned CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   asu_pkg::state_type state_ff, state_in;

   logic [NUM_WIDTH-1:0] n_ff, n_in;        // original number
   logic [NUM_WIDTH-1:0] rest_ff, rest_in;  // part not yet factored
   logic [NUM_WIDTH-1:0] d_ff, d_in;        // trial divisor
   logic [W-1:0]         geo_ff, geo_in;    // 1 + p + ... + p^e
   logic [W-1:0]         prod_ff, prod_in;  // running divisor sum
   logic                 pow_ff, pow_in;    // inside a prime power run

   // shared unit registers
   logic [W-1:0]         acc_ff, acc_in;    // remainder / product accumulator
   logic [W-1:0]         opa_ff, opa_in;    // dividend+quotient / multiplicand
   logic [W-1:0]         opb_ff, opb_in;    // divisor / multiplier
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;

   // shared adder
   logic [W-1:0]         add_x, add_y, add_sum;
   logic                 add_sub, add_co;

   logic [NUM_WIDTH-1:0] quot;
   logic                 rem_zero, d_le_q;
   logic [SAT_W-1:0]     diff_ext;

   always_comb begin
      add_x   = acc_ff;
      add_y   = opa_ff;
      add_sub = 1'b0;
      case (state_ff)
         asu_pkg::ST_DIV: begin
            // trial subtract of the divisor from the shifted partial remainder
            add_x   = {acc_ff[W-2:0], opa_ff[NUM_WIDTH-1]};
            add_y   = opb_ff;
            add_sub = 1'b1;
         end
         asu_pkg::ST_FINAL: begin
            add_x   = prod_ff;
            add_y   = W'(n_ff);
            add_sub = 1'b1;
         end
         default: ;
      endcase
      {add_co, add_sum} = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W+1)'(add_sub);
   end

   assign quot     = opa_ff[NUM_WIDTH-1:0];
   assign rem_zero = (acc_ff == '0);
   assign d_le_q   = (d_ff <= quot);
   assign diff_ext = SAT_W'(add_sum);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      rest_in      = rest_ff;
      d_in         = d_ff;
      geo_in       = geo_ff;
      prod_in      = prod_ff;
      pow_in       = pow_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;

      case (state_ff)
         asu_pkg::ST_IDLE: begin
            if (start) begin
               n_in     = req_number;
               rest_in  = req_number;
               d_in     = NUM_WIDTH'(asu_pkg::FIRST_DIVISOR);
               geo_in   = W'(1);
               prod_in  = W'(1);
               pow_in   = 1'b0;
               acc_in   = '0;
               opa_in   = W'(req_number);
               opb_in   = W'(asu_pkg::FIRST_DIVISOR);
               cnt_in   = '0;
               state_in = asu_pkg::ST_DIV;
            end
         end

         asu_pkg::ST_DIV: begin
            // restoring step: keep the difference when there is no borrow
            acc_in = add_co ? add_sum : add_x;
            opa_in = {opa_ff[W-2:0], add_co};
            if (cnt_ff == CNT_W'(NUM_WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = asu_pkg::ST_EVAL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         asu_pkg::ST_EVAL: begin
            if (rem_zero && (pow_ff || d_le_q)) begin
               // d divides: take it out and extend the geometric sum
               rest_in  = quot;
               pow_in   = 1'b1;
               acc_in   = W'(1);
               opa_in   = geo_ff;
               opb_in   = W'(d_ff);
               state_in = asu_pkg::ST_MGEO;
            end else if (pow_ff) begin
               // prime power run ended: fold its sum into the product
               pow_in   = 1'b0;
               d_in     = d_ff + NUM_WIDTH'(1);
               acc_in   = '0;
               opa_in   = prod_ff;
               opb_in   = geo_ff;
               state_in = asu_pkg::ST_MPROD;
            end else if (d_le_q) begin
               d_in     = d_ff + NUM_WIDTH'(1);
               acc_in   = '0;
               opa_in   = W'(rest_ff);
               opb_in   = W'(d_ff + NUM_WIDTH'(1));
               cnt_in   = '0;
               state_in = asu_pkg::ST_DIV;
            end else if (rest_ff > NUM_WIDTH'(1)) begin
               // leftover prime m: prod * m + prod
               acc_in   = prod_ff;
               opa_in   = prod_ff;
               opb_in   = W'(rest_ff);
               state_in = asu_pkg::ST_MLAST;
            end else begin
               state_in = asu_pkg::ST_FINAL;
            end
         end

         asu_pkg::ST_MGEO, asu_pkg::ST_MPROD, asu_pkg::ST_MLAST: begin
            if (opb_ff == '0) begin
               if (state_ff == asu_pkg::ST_MLAST) begin
                  prod_in  = acc_ff;
                  state_in = asu_pkg::ST_FINAL;
               end else begin
                  if (state_ff == asu_pkg::ST_MGEO) begin
                     geo_in = acc_ff;
                  end else begin
                     prod_in = acc_ff;
                     geo_in  = W'(1);
                  end
                  acc_in   = '0;
                  opa_in   = W'(rest_ff);
                  opb_in   = W'(d_ff);
                  cnt_in   = '0;
                  state_in = asu_pkg::ST_DIV;
               end
            end else begin
               if (opb_ff[0]) begin
                  acc_in = add_sum;
               end
               opa_in = {opa_ff[W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[W-1:1]};
            end
         end

         asu_pkg::ST_FINAL: begin
            if (n_ff == '0) begin
               rsp_sum_in = '0;
            end else if (diff_ext > SAT_W'(asu_pkg::SUM_MAX)) begin
               rsp_sum_in = asu_pkg::SUM_MAX;
            end else begin
               rsp_sum_in = SUM_W'(diff_ext);
            end
            rsp_valid_in = 1'b1;
            state_in     = asu_pkg::ST_IDLE;
         end

         default: begin
            state_in = asu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      rest_ff    <= rest_in;
      d_ff       <= d_in;
      geo_ff     <= geo_in;
      prod_ff    <= prod_in;
      pow_ff     <= pow_in;
      acc_ff     <= acc_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      cnt_ff     <= cnt_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign busy           = (state_ff != asu_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_proper_sum = rsp_sum_ff;

   // accepted beat starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not start work");

   // result only leaves from the final state
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == asu_pkg::ST_FINAL))
      else $error("result strobe outside final step");

   // after a result the unit is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result shown");

   // trial divisor never below two while dividing
   a_div_ge2: assert property (@(posedge clock) disable iff (reset)
      state_ff == asu_pkg::ST_DIV |-> d_ff >= NUM_WIDTH'(asu_pkg::FIRST_DIVISOR))
      else $error("trial divisor below two");

   // remainder from the divider stays below the divisor
   a_rem_lt_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == asu_pkg::ST_EVAL |-> acc_ff < opb_ff)
      else $error("remainder not below divisor");

endmodule
